>>> hdl/searchable_lifo_stack_assert.svh
// Assertion macros for the searchable LIFO stack checker.
// No dependencies; included by the checker file.
`ifndef SEARCHABLE_LIFO_STACK_ASSERT_SVH
`define SEARCHABLE_LIFO_STACK_ASSERT_SVH

// clocked assertion, disabled during reset
`define SLSK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, also checked during reset
`define SLSK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/slsk_pkg.sv
// Package for the searchable LIFO stack: field widths, command and status codes,
// cell control struct and sequencer states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slsk_pkg;

  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic push;
    logic pop;
    logic capture;
    logic scan;
  } slsk_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_t;

endpackage

`default_nettype wire

>>> hdl/slsk_if.sv
// Request and response channel interfaces of the searchable LIFO stack.
// Depends on slsk_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface slsk_req_if import slsk_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface slsk_res_if import slsk_pkg::*;;
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   data;
  logic                found;
  logic [POS_W-1:0]    position;
  logic [STATUS_W-1:0] status;
  logic [FILL_W-1:0]   fill;

  modport source (output valid, output data, output found, output position,
                  output status, output fill, input ready);
  modport sink   (input valid, input data, input found, input position,
                  input status, input fill, output ready);
endinterface

`default_nettype wire

>>> hdl/slsk_cell.sv
// One stack cell: a stored word plus a search match flag, shifting with its neighbors.
// Depends on slsk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slsk_cell import slsk_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int CW        = 5,
  parameter int INDEX     = 0
) (
  input  logic                 clk,
  input  slsk_ctrl_t           ctrl,
  input  logic [WORD_BITS-1:0] up_word,
  input  logic [WORD_BITS-1:0] dn_word,
  input  logic                 up_flag,
  input  logic [WORD_BITS-1:0] key,
  input  logic [CW-1:0]        count,
  output logic [WORD_BITS-1:0] word,
  output logic                 flag
);

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      word <= up_word;
    end else if (ctrl.pop) begin
      word <= dn_word;
    end
  end

  // cells at or above the fill level never match
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      flag <= (word == key) && (CW'(INDEX) < count);
    end else if (ctrl.scan) begin
      flag <= up_flag;
    end
  end

endmodule

`default_nettype wire

>>> hdl/searchable_lifo_stack.sv
// Top level of the searchable LIFO stack: sequencer, fill count, result register
// and the cell chain. Depends on slsk_pkg, slsk_if and slsk_cell.
//
//   channel  dir  payload                               handshake
//   req      in   cmd, value                            valid/ready
//   rsp      out  data, found, position, status, fill   valid/ready
//
// Push, pop, peek, clear: request latched, then executed in the chain.
// Search: match flags shift one cell per cycle toward the
//   bottom end of the chain, which is watched, so a match nearer the
//   bottom of the chain is found sooner; with no match every cell is scanned.
// Reset clears the fill count, the sequencer and the response valid flag; stored words are left as is.
// A latched request waits while the response register is full and unread.
`timescale 1ns / 1ps
`default_nettype none

module searchable_lifo_stack import slsk_pkg::*; #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  slsk_req_if.sink     req,
  slsk_res_if.source   rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = $clog2(DEPTH);

  state_t                state, state_next;
  slsk_ctrl_t            ctrl;
  logic [CMD_W-1:0]      cmd_q;
  logic [WORD_BITS-1:0]  key_q;
  logic [CW-1:0]         count, count_next;
  logic [PW-1:0]         scan_k;
  logic [CW:0]           pos_full;
  logic [WORD_BITS-1:0]  word [DEPTH];
  logic                  flag [DEPTH];

  logic                  rsp_valid;
  logic [DATA_W-1:0]     rsp_data, data_next;
  logic                  rsp_found, found_next;
  logic [POS_W-1:0]      rsp_position, pos_next;
  logic [STATUS_W-1:0]   rsp_status, status_next;
  logic [FILL_W-1:0]     rsp_fill;
  logic                  load_rsp;
  logic                  slot_free, scan_hit, scan_last;

  assign req.ready    = (state == S_IDLE);
  assign slot_free    = !rsp_valid || rsp.ready;
  assign scan_hit     = flag[DEPTH-1];
  assign scan_last    = (scan_k == PW'(DEPTH - 1));
  assign pos_full     = {1'b0, count} + (CW+1)'(scan_k) - (CW+1)'(DEPTH);

  assign rsp.valid    = rsp_valid;
  assign rsp.data     = rsp_data;
  assign rsp.found    = rsp_found;
  assign rsp.position = rsp_position;
  assign rsp.status   = rsp_status;
  assign rsp.fill     = rsp_fill;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (slot_free) state_next = (cmd_q == CMD_SEARCH) ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        if (scan_hit || scan_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl        = '0;
    load_rsp    = 1'b0;
    count_next  = count;
    data_next   = '0;
    found_next  = 1'b0;
    pos_next    = '0;
    status_next = ST_OK;
    unique case (state)
      S_IDLE: ;
      S_EXEC: begin
        if (slot_free) begin
          load_rsp = (cmd_q != CMD_SEARCH);
          unique case (cmd_q)
            CMD_PUSH: begin
              if (count == CW'(DEPTH)) begin
                status_next = ST_FULL;
              end else begin
                ctrl.push  = 1'b1;
                count_next = count + CW'(1);
              end
            end
            CMD_POP: begin
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else begin
                ctrl.pop   = 1'b1;
                count_next = count - CW'(1);
                data_next  = DATA_W'(word[0]);
              end
            end
            CMD_PEEK: begin
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else begin
                data_next = DATA_W'(word[0]);
              end
            end
            CMD_CLEAR:  count_next   = '0;
            CMD_SEARCH: ctrl.capture = 1'b1;
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        ctrl.scan  = 1'b1;
        load_rsp   = scan_hit || scan_last;
        found_next = scan_hit;
        pos_next   = scan_hit ? POS_W'(pos_full) : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd_q <= req.cmd;
      key_q <= WORD_BITS'(req.value);
    end
    if (ctrl.capture) begin
      scan_k <= '0;
    end else if (ctrl.scan) begin
      scan_k <= scan_k + PW'(1);
    end
    if (load_rsp) begin
      rsp_data     <= data_next;
      rsp_found    <= found_next;
      rsp_position <= pos_next;
      rsp_status   <= status_next;
      rsp_fill     <= FILL_W'(count_next);
    end
  end

  // cell 0 is the top of the stack
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] up_word, dn_word;
    logic                 up_flag;

    if (i == 0) begin : g_top
      assign up_word = key_q;
      assign up_flag = 1'b0;
    end else begin : g_mid
      assign up_word = word[i-1];
      assign up_flag = flag[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign dn_word = word[i];
    end else begin : g_inner
      assign dn_word = word[i+1];
    end

    slsk_cell #(
      .WORD_BITS (WORD_BITS),
      .CW        (CW),
      .INDEX     (i)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .up_word (up_word),
      .dn_word (dn_word),
      .up_flag (up_flag),
      .key     (key_q),
      .count   (count),
      .word    (word[i]),
      .flag    (flag[i])
    );
  end

endmodule

`default_nettype wire

>>> hdl/slsk_checker.sv
// Port-level checker for the searchable LIFO stack, bound to the top level.
// Depends on slsk_pkg and searchable_lifo_stack_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "searchable_lifo_stack_assert.svh"

module slsk_checker import slsk_pkg::*; #(
  parameter int DEPTH = 16
) (
  input logic                clk,
  input logic                rst,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [DATA_W-1:0]   rsp_data,
  input logic                rsp_found,
  input logic [POS_W-1:0]    rsp_position,
  input logic [STATUS_W-1:0] rsp_status,
  input logic [FILL_W-1:0]   rsp_fill
);

  logic full_rsp, full_ok, empty_rsp, empty_ok, found_rsp, pos_ok;

  assign full_rsp  = rsp_valid && (rsp_status == ST_FULL);
  assign full_ok   = (rsp_fill == FILL_W'(DEPTH));
  assign empty_rsp = rsp_valid && (rsp_status == ST_EMPTY);
  assign empty_ok  = (rsp_fill == '0) && (rsp_data == '0);
  assign found_rsp = rsp_valid && rsp_found && (DEPTH <= 16);
  assign pos_ok    = (FILL_W'(rsp_position) < rsp_fill);

  `SLSK_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped")

  `SLSK_ASSERT(a_full_fill, clk, rst, full_rsp |-> full_ok, "full status with stack not full")

  `SLSK_ASSERT(a_empty_fill, clk, rst, empty_rsp |-> empty_ok, "empty status with data or fill")

  `SLSK_ASSERT(a_found_pos, clk, rst, found_rsp |-> pos_ok, "match position above fill level")

endmodule

bind searchable_lifo_stack slsk_checker #(.DEPTH(DEPTH)) u_slsk_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_data     (rsp.data),
  .rsp_found    (rsp.found),
  .rsp_position (rsp.position),
  .rsp_status   (rsp.status),
  .rsp_fill     (rsp.fill)
);

`default_nettype wire

>>> tb/tb_searchable_lifo_stack.sv
// Testbench for searchable_lifo_stack: directed and random request streams, a
// shadow stack predicts every response. Depends on slsk_pkg, slsk_if and the RTL.
`timescale 1ns / 1ps

module tb_searchable_lifo_stack;
  import slsk_pkg::*;

  localparam int STACK_DEPTH    = 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_ITEMS   = 800;
  localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

  typedef struct packed {
    logic [DATA_W-1:0]   data;
    logic                found;
    logic [POS_W-1:0]    position;
    logic [STATUS_W-1:0] status;
    logic [FILL_W-1:0]   fill;
  } stack_reply_t;

  logic clk;
  logic rst;

  slsk_req_if req_ch ();
  slsk_res_if rsp_ch ();

  searchable_lifo_stack #(
    .DEPTH(STACK_DEPTH),
    .WORD_BITS(VALUE_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  logic [VALUE_W-1:0] shadow_words [STACK_DEPTH];
  int                 shadow_fill;
  stack_reply_t       reply_q [$];

  int  err_count;
  int  sent_count;
  int  checked_count;
  int  refused_pushes;
  int  empty_reads;
  int  search_hits;
  int  stall_cycles;
  bit  req_idle_on;
  bit  rsp_idle_on;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic stack_reply_t model_stack(input logic [CMD_W-1:0] c,
                                               input logic [VALUE_W-1:0] v);
    stack_reply_t r;
    r = '0;
    r.status = ST_OK;
    case (c)
      CMD_PUSH: begin
        if (shadow_fill >= STACK_DEPTH) begin
          r.status = ST_FULL;
          refused_pushes++;
        end else begin
          shadow_words[shadow_fill] = v;
          shadow_fill++;
        end
      end
      CMD_POP: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
          empty_reads++;
        end else begin
          shadow_fill--;
          r.data = shadow_words[shadow_fill];
        end
      end
      CMD_PEEK: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
          empty_reads++;
        end else begin
          r.data = shadow_words[shadow_fill-1];
        end
      end
      CMD_CLEAR: shadow_fill = 0;
      CMD_SEARCH: begin
        // walk down so the lowest match wins
        for (int i = shadow_fill - 1; i >= 0; i--) begin
          if (shadow_words[i] == v) begin
            r.found = 1'b1;
            r.position = i[POS_W-1:0];
          end
        end
        if (r.found) search_hits++;
      end
      default: ;
    endcase
    r.fill = shadow_fill[FILL_W-1:0];
    return r;
  endfunction

  // one request; returns right after the accepting edge with valid still high
  task automatic send_req(input logic [CMD_W-1:0] c, input logic [VALUE_W-1:0] v);
    while (req_idle_on && $urandom_range(0, 99) < 37) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd   <= c;
    req_ch.value <= v;
    @(negedge clk);
    while (!req_ch.ready) @(negedge clk);
    @(posedge clk);
    reply_q.push_back(model_stack(c, v));
    sent_count++;
  endtask

  task automatic compare_field(input string name, input logic [DATA_W-1:0] exp_v,
                               input logic [DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: response %s mismatch, expected %h actual %h", $time, name, exp_v,
               act_v);
      err_count++;
    end
  endtask

  task automatic check_reply();
    stack_reply_t e;
    if (reply_q.size() == 0) begin
      $display("%0t: response with no request outstanding, data %h status %0d", $time,
               rsp_ch.data, rsp_ch.status);
      err_count++;
    end else begin
      e = reply_q.pop_front();
      compare_field("data", e.data, rsp_ch.data);
      compare_field("found", e.found, rsp_ch.found);
      compare_field("position", e.position, rsp_ch.position);
      compare_field("status", e.status, rsp_ch.status);
      compare_field("fill", e.fill, rsp_ch.fill);
      checked_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rsp_idle_on) rsp_ch.ready <= ($urandom_range(0, 99) >= 37);
    else rsp_ch.ready <= 1'b1;
  end

  // handshakes are sampled mid-cycle, ahead of the edge that takes them
  always @(negedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) check_reply();
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  task automatic test_empty_stack();
    send_req(CMD_POP, 32'h1234_5678);
    send_req(CMD_PEEK, 32'hFFFF_FFFF);
    send_req(CMD_SEARCH, 32'h0000_0000);
    send_req(CMD_CLEAR, 32'h0000_0000);
    send_req(CMD_RSVD_HI, 32'hDEAD_BEEF);
  endtask

  task automatic test_fill_and_search();
    logic [VALUE_W-1:0] top_word;
    send_req(CMD_PUSH, 32'h0000_0000);
    send_req(CMD_PUSH, 32'hFFFF_FFFF);
    send_req(CMD_PUSH, 32'h0000_0000);
    top_word = '0;
    for (int i = 0; i < STACK_DEPTH - 3; i++) begin
      top_word = {$urandom} | 32'h0000_0100;
      send_req(CMD_PUSH, top_word);
    end
    send_req(CMD_PUSH, 32'hA5A5_A5A5);
    send_req(CMD_SEARCH, 32'h0000_0000);
    send_req(CMD_SEARCH, top_word);
    send_req(CMD_SEARCH, 32'h0000_00FF);
    send_req(CMD_PEEK, 32'h0000_0000);
    send_req(CMD_POP, 32'h0000_0000);
    send_req(CMD_CLEAR, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_traffic();
    int                 push_bias;
    int                 r;
    logic [CMD_W-1:0]   c;
    logic [VALUE_W-1:0] v;
    push_bias = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) push_bias = $urandom_range(15, 85);
      req_idle_on = !(n >= 300 && n < 450);
      rsp_idle_on = req_idle_on;
      r = $urandom_range(0, 99);
      if (r < push_bias) begin
        c = CMD_PUSH;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) c = CMD_POP;
        else if (r < 60) c = CMD_PEEK;
        else if (r < 90) c = CMD_SEARCH;
        else if (r < 95) c = CMD_CLEAR;
        else c = CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
      end
      r = $urandom_range(0, 99);
      if (c == CMD_SEARCH && shadow_fill > 0 && r < 70) begin
        v = shadow_words[$urandom_range(0, shadow_fill - 1)];
      end else if (r < 60) v = $urandom;
      else if (r < 85) v = VALUE_W'($urandom_range(0, 7));
      else if (r < 92) v = '0;
      else v = '1;
      send_req(c, v);
    end
    req_idle_on = 1'b1;
    rsp_idle_on = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_PUSH;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    shadow_fill = 0;
    err_count = 0;
    sent_count = 0;
    checked_count = 0;
    refused_pushes = 0;
    empty_reads = 0;
    search_hits = 0;
    stall_cycles = 0;
    req_idle_on = 1'b1;
    rsp_idle_on = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_empty_stack();
    test_fill_and_search();
    test_random_traffic();

    req_ch.valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests sent, %0d responses checked", sent_count, checked_count);
    $display("%0d full-stack push refusals, %0d empty pops/peeks, %0d search hits",
             refused_pushes, empty_reads, search_hits);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
